[rtl/core/ptc_pkg.sv]
package ptc_pkg;

    // configuration port geometry
    localparam int ADDR_W = 5;
    localparam int DATA_W = 64;

    // divider geometry: divisor magnitude is at most 2**30
    localparam int NUM_W  = 64;
    localparam int DEN_W  = 31;
    localparam int REM_W  = 30;

    // pipeline depths
    localparam int FRONT_LAT = 12;
    localparam int BACK_LAT  = 7;

    // fixed scaling constants of the compensation
    localparam logic signed [16:0] NUM_SCALE  = 17'sd3125;
    localparam logic signed [32:0] T_OFFSET   = 33'sd128000;
    localparam logic [20:0]        P_FULL     = 21'd1048576;
    localparam logic [63:0]        V1_BIAS    = 64'h0000_8000_0000_0000;
    localparam logic [31:0]        T_ROUND    = 32'd128;

    // register map
    typedef enum logic [1:0] {
        REG_TEMP  = 2'd0,
        REG_PLOW  = 2'd1,
        REG_PHIGH = 2'd2,
        REG_NINE  = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [19:0] raw_pressure;
        logic [19:0] raw_temperature;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] temperature_centi;
        logic [31:0]        pressure_q24_8;
    } t_out_item;

    typedef struct packed {
        logic [15:0] t1;
        logic [15:0] t2;
        logic [15:0] t3;
        logic [15:0] p1;
        logic [15:0] p2;
        logic [15:0] p3;
        logic [15:0] p4;
        logic [15:0] p5;
        logic [15:0] p6;
        logic [15:0] p7;
        logic [15:0] p8;
        logic [15:0] p9;
    } t_coef;

    typedef struct packed {
        logic [31:0] temp;
        logic        zero;
        logic        qneg;
    } t_side;

    typedef struct packed {
        logic [NUM_W-1:0] un;
        logic [DEN_W-1:0] ud;
        t_side            side;
    } t_div_in;

    // low partial product of a 64-bit word by a signed coefficient, sign extended
    function automatic logic [63:0] pp_lo(input logic [31:0] x, input logic signed [16:0] c);
        logic signed [32:0] xs;
        logic signed [49:0] pr;
        xs = $signed({1'b0, x});
        pr = xs * c;
        return {{14{pr[49]}}, pr};
    endfunction

    // high partial product, only the bits that land below 2**64
    function automatic logic [31:0] pp_hi(input logic [31:0] x, input logic signed [16:0] c);
        logic [31:0] cx;
        cx = {{15{c[16]}}, c};
        return x * cx;
    endfunction

endpackage

[rtl/core/ptc_cfg.sv]
module ptc_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ptc_pkg::ADDR_W-1:0]  paddr,
    input  logic [ptc_pkg::DATA_W-1:0]  pwdata,
    output logic [ptc_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output ptc_pkg::t_coef              o_coef
);

    logic [47:0] r_temp;
    logic [63:0] r_plow;
    logic [63:0] r_phigh;
    logic [15:0] r_nine;
    logic        w_wr;
    ptc_pkg::t_reg_idx w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = ptc_pkg::t_reg_idx'(paddr[4:3]);

    // register write on the access phase of a transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp  <= '0;
            r_plow  <= '0;
            r_phigh <= '0;
            r_nine  <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                ptc_pkg::REG_TEMP:  r_temp  <= pwdata[47:0];
                ptc_pkg::REG_PLOW:  r_plow  <= pwdata;
                ptc_pkg::REG_PHIGH: r_phigh <= pwdata;
                ptc_pkg::REG_NINE:  r_nine  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (w_idx)
            ptc_pkg::REG_TEMP:  prdata = {16'd0, r_temp};
            ptc_pkg::REG_PLOW:  prdata = r_plow;
            ptc_pkg::REG_PHIGH: prdata = r_phigh;
            ptc_pkg::REG_NINE:  prdata = {48'd0, r_nine};
            default:            prdata = '0;
        endcase
    end

    // coefficient slices
    assign o_coef.t1 = r_temp[15:0];
    assign o_coef.t2 = r_temp[31:16];
    assign o_coef.t3 = r_temp[47:32];
    assign o_coef.p1 = r_plow[15:0];
    assign o_coef.p2 = r_plow[31:16];
    assign o_coef.p3 = r_plow[47:32];
    assign o_coef.p4 = r_plow[63:48];
    assign o_coef.p5 = r_phigh[15:0];
    assign o_coef.p6 = r_phigh[31:16];
    assign o_coef.p7 = r_phigh[47:32];
    assign o_coef.p8 = r_phigh[63:48];
    assign o_coef.p9 = r_nine;

endmodule

[rtl/core/ptc_front.sv]
module ptc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  ptc_pkg::t_in_item i_item,
    input  ptc_pkg::t_coef    i_coef,
    output logic              o_vld,
    output ptc_pkg::t_div_in  o_div
);

    logic [ptc_pkg::FRONT_LAT-1:0] r_vld;
    logic [19:0] r_adcp [8];
    logic [31:0] r_tmp  [8];

    logic [31:0] w_t2x, w_t3x;
    logic signed [15:0] w_p5, w_p2;
    logic signed [16:0] w_p1x, w_p3x, w_p6x;
    logic [63:0] w_p4s;

    logic [31:0] w_a, w_d, w_dds, w_tv2, w_f5, w_mag;
    logic signed [32:0] w_v1;
    logic [20:0] w_pp;
    logic [63:0] w_dsum;

    logic [31:0] r1_m1, r1_dd, r2_tv1, r2_m2, r3_fine;
    logic signed [32:0] r4_v1;
    logic [63:0] r5_sq;
    logic signed [48:0] r5_pv5, r5_pv2;
    logic [63:0] r6_lo6, r6_lo3, r6_x5, r6_x2;
    logic [31:0] r6_hi6, r6_hi3;
    logic [63:0] r7_c6, r7_c3, r7_x5, r7_x2;
    logic [63:0] r8_v2, r8_v1;
    logic [63:0] r9_lo, r9_nb;
    logic [31:0] r9_hi;
    logic [ptc_pkg::DEN_W-1:0] r10_den;
    logic [63:0] r10_nlo;
    logic [31:0] r10_nhi;
    logic [63:0] r11_num;
    logic [ptc_pkg::DEN_W-1:0] r11_ud;
    logic r11_dneg, r11_zero;
    ptc_pkg::t_div_in r_div;

    // coefficient forms
    assign w_t2x = {{16{i_coef.t2[15]}}, i_coef.t2};
    assign w_t3x = {{16{i_coef.t3[15]}}, i_coef.t3};
    assign w_p5  = $signed(i_coef.p5);
    assign w_p2  = $signed(i_coef.p2);
    assign w_p1x = $signed({1'b0, i_coef.p1});
    assign w_p3x = $signed({i_coef.p3[15], i_coef.p3});
    assign w_p6x = $signed({i_coef.p6[15], i_coef.p6});
    assign w_p4s = {{48{i_coef.p4[15]}}, i_coef.p4} << 35;

    // valid travels with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[ptc_pkg::FRONT_LAT-2:0], i_vld};
        end
    end

    // side data delay lines
    always_ff @(posedge i_clk) begin
        r_adcp[0] <= i_item.raw_pressure;
        for (int k = 1; k < 8; k++) r_adcp[k] <= r_adcp[k-1];
        r_tmp[0] <= 32'($signed(w_f5) >>> 8);
        for (int k = 1; k < 8; k++) r_tmp[k] <= r_tmp[k-1];
    end

    // temperature differences
    assign w_a = {15'd0, i_item.raw_temperature[19:3]} - {15'd0, i_coef.t1, 1'b0};
    assign w_d = {16'd0, i_item.raw_temperature[19:4]} - {16'd0, i_coef.t1};

    // stages 1 to 4: fine temperature, offset and centi-degrees
    assign w_dds = 32'($signed(r1_dd) >>> 12);
    assign w_tv2 = 32'($signed(r2_m2) >>> 14);
    assign w_v1  = $signed({r3_fine[31], r3_fine}) - ptc_pkg::T_OFFSET;
    assign w_f5  = {r3_fine[29:0], 2'b00} + r3_fine + ptc_pkg::T_ROUND;

    always_ff @(posedge i_clk) begin
        r1_m1   <= w_a * w_t2x;
        r1_dd   <= w_d * w_d;
        r2_tv1  <= 32'($signed(r1_m1) >>> 11);
        r2_m2   <= w_dds * w_t3x;
        r3_fine <= r2_tv1 + w_tv2;
        r4_v1   <= w_v1;
    end

    // stages 5 to 8: divisor and numerator polynomial terms
    assign w_mag = r4_v1[32] ? 32'(-r4_v1) : r4_v1[31:0];

    always_ff @(posedge i_clk) begin
        r5_sq  <= w_mag * w_mag;
        r5_pv5 <= r4_v1 * w_p5;
        r5_pv2 <= r4_v1 * w_p2;
        r6_lo6 <= ptc_pkg::pp_lo(r5_sq[31:0], w_p6x);
        r6_hi6 <= ptc_pkg::pp_hi(r5_sq[63:32], w_p6x);
        r6_lo3 <= ptc_pkg::pp_lo(r5_sq[31:0], w_p3x);
        r6_hi3 <= ptc_pkg::pp_hi(r5_sq[63:32], w_p3x);
        r6_x5  <= {{15{r5_pv5[48]}}, r5_pv5} << 17;
        r6_x2  <= {{15{r5_pv2[48]}}, r5_pv2} << 12;
        r7_c6  <= r6_lo6 + {r6_hi6, 32'd0};
        r7_c3  <= r6_lo3 + {r6_hi3, 32'd0};
        r7_x5  <= r6_x5;
        r7_x2  <= r6_x2;
        r8_v2  <= r7_c6 + r7_x5 + w_p4s;
        r8_v1  <= 64'($signed(r7_c3) >>> 8) + r7_x2 + ptc_pkg::V1_BIAS;
    end

    // stages 9 to 12: divisor scaling, numerator scaling, magnitudes
    assign w_pp   = ptc_pkg::P_FULL - {1'b0, r_adcp[7]};
    assign w_dsum = r9_lo + {r9_hi, 32'd0};

    always_ff @(posedge i_clk) begin
        r9_lo    <= ptc_pkg::pp_lo(r8_v1[31:0], w_p1x);
        r9_hi    <= ptc_pkg::pp_hi(r8_v1[63:32], w_p1x);
        r9_nb    <= ({43'd0, w_pp} << 31) - r8_v2;
        r10_den  <= w_dsum[63:33];
        r10_nlo  <= ptc_pkg::pp_lo(r9_nb[31:0], ptc_pkg::NUM_SCALE);
        r10_nhi  <= ptc_pkg::pp_hi(r9_nb[63:32], ptc_pkg::NUM_SCALE);
        r11_num  <= r10_nlo + {r10_nhi, 32'd0};
        r11_ud   <= r10_den[ptc_pkg::DEN_W-1] ? (ptc_pkg::DEN_W'(0) - r10_den) : r10_den;
        r11_dneg <= r10_den[ptc_pkg::DEN_W-1];
        r11_zero <= (r10_den == '0);
        r_div.un        <= r11_num[63] ? (64'd0 - r11_num) : r11_num;
        r_div.ud        <= r11_ud;
        r_div.side.temp <= r_tmp[7];
        r_div.side.zero <= r11_zero;
        r_div.side.qneg <= r11_num[63] ^ r11_dneg;
    end

    assign o_vld = r_vld[ptc_pkg::FRONT_LAT-1];
    assign o_div = r_div;

endmodule

[rtl/core/ptc_div.sv]
module ptc_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_vld,
    input  ptc_pkg::t_div_in          i_div,
    output logic                      o_vld,
    output logic [ptc_pkg::NUM_W-1:0] o_q,
    output ptc_pkg::t_side            o_side
);

    localparam int STEPS = ptc_pkg::NUM_W;

    logic [STEPS-1:0]           r_vld;
    logic [ptc_pkg::NUM_W-1:0]  r_num  [STEPS];
    logic [ptc_pkg::REM_W-1:0]  r_rem  [STEPS];
    logic [ptc_pkg::DEN_W-1:0]  r_ud   [STEPS];
    ptc_pkg::t_side             r_side [STEPS];

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[STEPS-2:0], i_vld};
        end
    end

    // one restoring quotient bit per stage
    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic [ptc_pkg::NUM_W-1:0] w_num;
        logic [ptc_pkg::REM_W-1:0] w_rem;
        logic [ptc_pkg::DEN_W-1:0] w_ud;
        ptc_pkg::t_side            w_side;
        logic [ptc_pkg::DEN_W-1:0] w_trial;
        logic                      w_ge;

        if (k == 0) begin : g_first
            assign w_num  = i_div.un;
            assign w_rem  = '0;
            assign w_ud   = i_div.ud;
            assign w_side = i_div.side;
        end else begin : g_next
            assign w_num  = r_num[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_ud   = r_ud[k-1];
            assign w_side = r_side[k-1];
        end

        assign w_trial = {w_rem, w_num[ptc_pkg::NUM_W-1]};
        assign w_ge    = (w_trial >= w_ud);

        always_ff @(posedge i_clk) begin
            r_num[k]  <= {w_num[ptc_pkg::NUM_W-2:0], w_ge};
            r_rem[k]  <= w_ge ? ptc_pkg::REM_W'(w_trial - w_ud) : w_trial[ptc_pkg::REM_W-1:0];
            r_ud[k]   <= w_ud;
            r_side[k] <= w_side;
        end
    end

    assign o_vld  = r_vld[STEPS-1];
    assign o_q    = r_num[STEPS-1];
    assign o_side = r_side[STEPS-1];

    // partial remainder stays below the divisor magnitude
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[STEPS-1] && !r_side[STEPS-1].zero) |->
        ({1'b0, r_rem[STEPS-1]} < r_ud[STEPS-1]))
        else $error("remainder not below divisor");

    // first stage remainder bound as well
    a_rem_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[0] && !r_side[0].zero) |-> ({1'b0, r_rem[0]} < r_ud[0]))
        else $error("first stage remainder not below divisor");

endmodule

[rtl/core/ptc_back.sv]
module ptc_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_vld,
    input  logic [ptc_pkg::NUM_W-1:0] i_q,
    input  ptc_pkg::t_side            i_side,
    input  ptc_pkg::t_coef            i_coef,
    output logic                      o_vld,
    output ptc_pkg::t_out_item        o_result
);

    logic [ptc_pkg::BACK_LAT-1:0] r_vld;
    ptc_pkg::t_side r_side [6];

    logic signed [16:0] w_p8x, w_p9x;
    logic [31:0] w_p7s;
    logic [63:0] w_s, w_c8, w_c9;

    logic [63:0] r1_p, r2_p, r3_p, r4_p, r5_p;
    logic [63:0] r2_sll, r2_lo8;
    logic [31:0] r2_slh, r2_hi8;
    logic [63:0] r3_sq, r3_v2, r4_v2, r5_v2;
    logic [63:0] r4_lo9;
    logic [31:0] r4_hi9;
    logic [63:0] r5_v1, r6_sum;
    ptc_pkg::t_out_item r_result;

    assign w_p8x = $signed({i_coef.p8[15], i_coef.p8});
    assign w_p9x = $signed({i_coef.p9[15], i_coef.p9});
    assign w_p7s = {{12{i_coef.p7[15]}}, i_coef.p7, 4'd0};

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[ptc_pkg::BACK_LAT-2:0], i_vld};
        end
    end

    // side data delay line
    always_ff @(posedge i_clk) begin
        r_side[0] <= i_side;
        for (int k = 1; k < 6; k++) r_side[k] <= r_side[k-1];
    end

    assign w_s  = 64'($signed(r1_p) >>> 13);
    assign w_c8 = r2_lo8 + {r2_hi8, 32'd0};
    assign w_c9 = r4_lo9 + {r4_hi9, 32'd0};

    // quotient sign, square and correction terms
    always_ff @(posedge i_clk) begin
        r1_p   <= i_side.qneg ? (64'd0 - i_q) : i_q;
        r2_sll <= w_s[31:0] * w_s[31:0];
        r2_slh <= w_s[31:0] * w_s[63:32];
        r2_lo8 <= ptc_pkg::pp_lo(r1_p[31:0], w_p8x);
        r2_hi8 <= ptc_pkg::pp_hi(r1_p[63:32], w_p8x);
        r2_p   <= r1_p;
        r3_sq  <= r2_sll + {r2_slh[30:0], 33'd0};
        r3_v2  <= 64'($signed(w_c8) >>> 19);
        r3_p   <= r2_p;
        r4_lo9 <= ptc_pkg::pp_lo(r3_sq[31:0], w_p9x);
        r4_hi9 <= ptc_pkg::pp_hi(r3_sq[63:32], w_p9x);
        r4_v2  <= r3_v2;
        r4_p   <= r3_p;
        r5_v1  <= 64'($signed(w_c9) >>> 25);
        r5_v2  <= r4_v2;
        r5_p   <= r4_p;
        r6_sum <= r5_p + r5_v1 + r5_v2;
    end

    // final scaling and zero divisor case
    always_ff @(posedge i_clk) begin
        r_result.temperature_centi <= $signed(r_side[5].temp);
        r_result.pressure_q24_8    <= r_side[5].zero ? 32'd0 : (r6_sum[39:8] + w_p7s);
    end

    assign o_vld    = r_vld[ptc_pkg::BACK_LAT-1];
    assign o_result = r_result;

endmodule

[rtl/core/pressure_temperature_compensation.sv]
// an accepted start reaches the o_valid strobe through the pipeline stages
// (12 polynomial stages, 64 divider stages, 7 correction stages)
// throughput: one item per cycle; busy stays low, start is taken every cycle
// results are strobed for one cycle and cannot be stalled by the receiver
// synchronous active-low reset clears the valid bits and zeroes all coefficients
module pressure_temperature_compensation (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  ptc_pkg::t_in_item           i_data,
    output logic                        o_valid,
    output ptc_pkg::t_out_item          o_result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ptc_pkg::ADDR_W-1:0]  paddr,
    input  logic [ptc_pkg::DATA_W-1:0]  pwdata,
    output logic [ptc_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    localparam int LAT = ptc_pkg::FRONT_LAT + ptc_pkg::NUM_W + ptc_pkg::BACK_LAT;

    ptc_pkg::t_coef            w_coef;
    logic                      w_fr_vld;
    ptc_pkg::t_div_in          w_div;
    logic                      w_dv_vld;
    logic [ptc_pkg::NUM_W-1:0] w_q;
    ptc_pkg::t_side            w_side;
    logic                      w_acc;

    // the pipeline never stalls
    assign busy  = 1'b0;
    assign w_acc = start & ~busy;

    ptc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_coef  (w_coef)
    );

    ptc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_acc),
        .i_item  (i_data),
        .i_coef  (w_coef),
        .o_vld   (w_fr_vld),
        .o_div   (w_div)
    );

    ptc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_fr_vld),
        .i_div   (w_div),
        .o_vld   (w_dv_vld),
        .o_q     (w_q),
        .o_side  (w_side)
    );

    ptc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (w_dv_vld),
        .i_q      (w_q),
        .i_side   (w_side),
        .i_coef   (w_coef),
        .o_vld    (o_valid),
        .o_result (o_result)
    );

    // every result traces back to a start transfer a fixed latency earlier
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LAT))
        else $error("result without matching start");

endmodule

[tb/sv/pressure_temperature_compensation_tb.sv]
module pressure_temperature_compensation_tb;

    localparam int LATENCY   = 83;
    localparam int WDOG_MAX  = 2000;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           start;
    logic                           busy;
    ptc_pkg::t_in_item              i_data;
    logic                           o_valid;
    ptc_pkg::t_out_item             o_result;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [ptc_pkg::ADDR_W-1:0]     paddr;
    logic [ptc_pkg::DATA_W-1:0]     pwdata;
    logic [ptc_pkg::DATA_W-1:0]     prdata;
    logic                           pready;

    // coefficient shadow used by the predictor
    logic [47:0] cal_temp;
    logic [63:0] cal_plow;
    logic [63:0] cal_phigh;
    logic [15:0] cal_nine;

    ptc_pkg::t_out_item compensated_q[$];
    int          mismatch_count;
    int          idle_cycles;
    bit          no_gaps;

    pressure_temperature_compensation dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_data   (i_data),
        .o_valid  (o_valid),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // arithmetic right shifts on two's-complement words
    function automatic logic [31:0] sra32(input logic [31:0] x, input int s);
        return $unsigned($signed(x) >>> s);
    endfunction

    function automatic logic [63:0] sra64(input logic [63:0] x, input int s);
        return $unsigned($signed(x) >>> s);
    endfunction

    function automatic logic [63:0] sx16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    // expected compensated temperature and pressure for one reading pair
    function automatic ptc_pkg::t_out_item compensate(input ptc_pkg::t_in_item raw);
        ptc_pkg::t_out_item res;
        logic [31:0] t1, t2, t3, a, tv1, d, tv2, fine, temp;
        logic [63:0] v1, v2, p, un, ud, q;
        logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        t1 = {16'd0, cal_temp[15:0]};
        t2 = {{16{cal_temp[31]}}, cal_temp[31:16]};
        t3 = {{16{cal_temp[47]}}, cal_temp[47:32]};
        p1 = {48'd0, cal_plow[15:0]};
        p2 = sx16(cal_plow[31:16]);
        p3 = sx16(cal_plow[47:32]);
        p4 = sx16(cal_plow[63:48]);
        p5 = sx16(cal_phigh[15:0]);
        p6 = sx16(cal_phigh[31:16]);
        p7 = sx16(cal_phigh[47:32]);
        p8 = sx16(cal_phigh[63:48]);
        p9 = sx16(cal_nine);
        // temperature path, 32-bit wrap
        a    = {12'd0, raw.raw_temperature} >> 3;
        a    = a - (t1 << 1);
        tv1  = sra32(a * t2, 11);
        d    = ({12'd0, raw.raw_temperature} >> 4) - t1;
        tv2  = sra32(sra32(d * d, 12) * t3, 14);
        fine = tv1 + tv2;
        temp = sra32(fine * 32'd5 + 32'd128, 8);
        // pressure path, 64-bit wrap
        v1 = {{32{fine[31]}}, fine} - 64'd128000;
        v2 = v1 * v1 * p6;
        v2 = v2 + ((v1 * p5) << 17);
        v2 = v2 + (p4 << 35);
        v1 = sra64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
        v1 = sra64(((64'd1 << 47) + v1) * p1, 33);
        res.temperature_centi = temp;
        if (v1 == 64'd0) begin
            res.pressure_q24_8 = 32'd0;
        end else begin
            p  = 64'd1048576 - {44'd0, raw.raw_pressure};
            p  = ((p << 31) - v2) * 64'd3125;
            un = p[63] ? -p : p;
            ud = v1[63] ? -v1 : v1;
            q  = un / ud;
            p  = (p[63] != v1[63]) ? -q : q;
            v1 = sra64(p9 * sra64(p, 13) * sra64(p, 13), 25);
            v2 = sra64(p8 * p, 19);
            p  = sra64(p + v1 + v2, 8) + (p7 << 4);
            res.pressure_q24_8 = p[31:0];
        end
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        mismatch_count++;
    endtask

    // result checker and watchdog
    always @(posedge i_clk) begin
        ptc_pkg::t_out_item exp_res;
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if (o_valid || (start && !busy)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (o_valid) begin
                if (compensated_q.size() == 0) begin
                    report_mismatch("result with nothing expected");
                end else begin
                    exp_res = compensated_q.pop_front();
                    if (o_result.temperature_centi !== exp_res.temperature_centi)
                        report_mismatch($sformatf("temperature_centi got %0d exp %0d",
                            o_result.temperature_centi, exp_res.temperature_centi));
                    if (o_result.pressure_q24_8 !== exp_res.pressure_q24_8)
                        report_mismatch($sformatf("pressure_q24_8 got %h exp %h",
                            o_result.pressure_q24_8, exp_res.pressure_q24_8));
                end
            end
            if (idle_cycles >= WDOG_MAX) begin
                $display("watchdog expired");
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic apb_write(input ptc_pkg::t_reg_idx idx, input logic [63:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            ptc_pkg::REG_TEMP:  cal_temp  = value[47:0];
            ptc_pkg::REG_PLOW:  cal_plow  = value;
            ptc_pkg::REG_PHIGH: cal_phigh = value;
            default:            cal_nine  = value[15:0];
        endcase
    endtask

    task automatic set_coeffs(input logic [47:0] tc, input logic [63:0] lo,
                              input logic [63:0] hi, input logic [15:0] nine);
        apb_write(ptc_pkg::REG_TEMP, {16'd0, tc});
        apb_write(ptc_pkg::REG_PLOW, lo);
        apb_write(ptc_pkg::REG_PHIGH, hi);
        apb_write(ptc_pkg::REG_NINE, {48'd0, nine});
    endtask

    // drive one reading pair, hold until the transfer
    task automatic send_reading(input logic [19:0] rp, input logic [19:0] rt);
        ptc_pkg::t_in_item item;
        int gap;
        if (!no_gaps && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            gap = $urandom_range(1, 18);
            repeat (gap) @(posedge i_clk);
        end
        item.raw_pressure    = rp;
        item.raw_temperature = rt;
        start  <= 1'b1;
        i_data <= item;
        do @(posedge i_clk); while (busy);
        compensated_q.push_back(compensate(item));
    endtask

    task automatic drain();
        start <= 1'b0;
        while (compensated_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    // typical datasheet calibration
    task automatic load_typical();
        set_coeffs({16'hFC18, 16'h6822, 16'h6B4E},
                   {16'h1770, 16'h0BB8, 16'hD6D0, 16'h9400},
                   {16'hFF38, 16'h3D70, 16'h0001, 16'h0000},
                   16'd6000);
    endtask

    task automatic test_directed_extremes();
        load_typical();
        send_reading(20'd0, 20'd0);
        send_reading(20'hFFFFF, 20'hFFFFF);
        send_reading(20'd0, 20'hFFFFF);
        send_reading(20'hFFFFF, 20'd0);
        send_reading(20'h65A00, 20'h7E800);
        send_reading(20'h5A5A5, 20'hA5A5A);
        send_reading(20'hA5A5A, 20'h5A5A5);
        drain();
    endtask

    task automatic test_zero_divisor();
        // reset coefficients give p1 = 0, so the divisor is zero
        send_reading(20'h12345, 20'h7E800);
        send_reading(20'hFFFFF, 20'd0);
        drain();
    endtask

    task automatic test_coeff_extremes();
        set_coeffs(48'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                   64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
        send_reading(20'h80000, 20'h80000);
        send_reading(20'hFFFFF, 20'd1);
        drain();
        set_coeffs({16'h8000, 16'h8000, 16'hFFFF}, {16'h8000, 16'h8000, 16'h8000, 16'hFFFF},
                   {16'h8000, 16'h8000, 16'h8000, 16'h8000}, 16'h8000);
        send_reading(20'd1, 20'hFFFFF);
        send_reading(20'h7FFFF, 20'h00010);
        drain();
        set_coeffs({16'h7FFF, 16'h7FFF, 16'h0000}, {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0001},
                   {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 16'h7FFF);
        send_reading(20'hFFFFF, 20'hFFFFF);
        send_reading(20'd0, 20'h00008);
        drain();
    endtask

    task automatic test_random_phases();
        for (int ph = 0; ph < 6; ph++) begin
            if (ph % 2 == 0)
                load_typical();
            else
                set_coeffs(48'({$urandom, $urandom}),
                           {$urandom, $urandom}, {$urandom, $urandom}, 16'($urandom));
            if (ph == 5) no_gaps = 1;
            for (int n = 0; n < 100; n++)
                send_reading(20'($urandom_range(0, 20'hFFFFF)),
                             20'($urandom_range(0, 20'hFFFFF)));
            drain();
        end
    endtask

    initial begin
        mismatch_count = 0;
        no_gaps   = 0;
        cal_temp  = '0;
        cal_plow  = '0;
        cal_phigh = '0;
        cal_nine  = '0;
        i_rst_n   = 1'b0;
        start     = 1'b0;
        i_data    = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_zero_divisor();
        test_directed_extremes();
        test_coeff_extremes();
        test_random_phases();
        repeat (LATENCY + 20) @(posedge i_clk);
        if (mismatch_count == 0 && compensated_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[pressure_temperature_compensation.f]
rtl/core/ptc_pkg.sv
rtl/core/ptc_cfg.sv
rtl/core/ptc_front.sv
rtl/core/ptc_div.sv
rtl/core/ptc_back.sv
rtl/core/pressure_temperature_compensation.sv
tb/sv/pressure_temperature_compensation_tb.sv
